// ----- src/cibl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibl_pkg
// Constant tables for the collision integral lookup: axis nodes, per-interval
// reciprocals and the Omega(2,2) table in units of 1e-5.
// ----------------------------------------------------------------------------
package cibl_pkg;

   localparam int TEMP_ROWS   = 37;
   localparam int DIPOLE_COLS = 8;
   localparam int LATENCY     = 10;

   localparam int T_IDX_W = $clog2(TEMP_ROWS - 1);
   localparam int D_IDX_W = $clog2(DIPOLE_COLS - 1);

   typedef logic [22:0] t_node_type;
   typedef logic [17:0] d_node_type;
   typedef logic [20:0] omega_type;
   typedef logic [16:0] frac_type;

   // T* nodes, Q7.16
   localparam t_node_type T_AXIS [TEMP_ROWS] = '{
      23'd6554, 23'd13107, 23'd19661, 23'd26214, 23'd32768, 23'd39322, 23'd45875,
      23'd52429, 23'd58982, 23'd65536, 23'd78643, 23'd91750, 23'd104858,
      23'd117965, 23'd131072, 23'd163840, 23'd196608, 23'd229376, 23'd262144,
      23'd327680, 23'd393216, 23'd458752, 23'd524288, 23'd589824, 23'd655360,
      23'd786432, 23'd917504, 23'd1048576, 23'd1179648, 23'd1310720,
      23'd1638400, 23'd1966080, 23'd2293760, 23'd2621440, 23'd3276800,
      23'd4915200, 23'd6553600
   };

   // rounded 2^32 / interval width
   localparam logic [19:0] T_RECIP [TEMP_ROWS-1] = '{
      20'd655420, 20'd655320, 20'd655420, 20'd655320, 20'd655320, 20'd655420,
      20'd655320, 20'd655420, 20'd655320, 20'd327685, 20'd327685, 20'd327660,
      20'd327685, 20'd327685, 20'd131072, 20'd131072, 20'd131072, 20'd131072,
      20'd65536, 20'd65536, 20'd65536, 20'd65536, 20'd65536, 20'd65536,
      20'd32768, 20'd32768, 20'd32768, 20'd32768, 20'd32768,
      20'd13107, 20'd13107, 20'd13107, 20'd13107, 20'd6554, 20'd2621, 20'd2621
   };

   // delta* nodes, Q2.16
   localparam d_node_type D_AXIS [DIPOLE_COLS] = '{
      18'd0, 18'd16384, 18'd32768, 18'd49152, 18'd65536, 18'd98304, 18'd131072,
      18'd163840
   };

   localparam logic [18:0] D_RECIP [DIPOLE_COLS-1] = '{
      19'd262144, 19'd262144, 19'd262144, 19'd262144, 19'd131072, 19'd131072,
      19'd131072
   };

   localparam omega_type OMEGA_ROM [TEMP_ROWS][DIPOLE_COLS] = '{
      '{21'd410050, 21'd426600, 21'd483300, 21'd574200, 21'd672900, 21'd862400, 21'd1034000, 21'd1189000},
      '{21'd326260, 21'd330500, 21'd351600, 21'd391400, 21'd443300, 21'd557000, 21'd663700, 21'd761800},
      '{21'd283990, 21'd283600, 21'd293600, 21'd316800, 21'd351100, 21'd432900, 21'd512600, 21'd587400},
      '{21'd253100, 21'd252200, 21'd258600, 21'd274900, 21'd300400, 21'd364000, 21'd428200, 21'd489500},
      '{21'd228370, 21'd227700, 21'd232900, 21'd246000, 21'd266500, 21'd318700, 21'd372700, 21'd424900},
      '{21'd208380, 21'd208100, 21'd213000, 21'd224300, 21'd241700, 21'd286200, 21'd332900, 21'd378600},
      '{21'd192200, 21'd192400, 21'd197000, 21'd207200, 21'd222500, 21'd261400, 21'd302800, 21'd343500},
      '{21'd179020, 21'd179500, 21'd184000, 21'd193400, 21'd207000, 21'd241700, 21'd278800, 21'd315600},
      '{21'd168230, 21'd168900, 21'd173300, 21'd182000, 21'd194400, 21'd225800, 21'd259600, 21'd293300},
      '{21'd159290, 21'd160100, 21'd164400, 21'd172500, 21'd183800, 21'd212400, 21'd243500, 21'd274600},
      '{21'd145510, 21'd146500, 21'd150400, 21'd157400, 21'd167000, 21'd191300, 21'd218100, 21'd245100},
      '{21'd135510, 21'd136500, 21'd140000, 21'd146100, 21'd154400, 21'd175400, 21'd198900, 21'd222800},
      '{21'd128000, 21'd128900, 21'd132100, 21'd137400, 21'd144700, 21'd163000, 21'd183800, 21'd205300},
      '{21'd122190, 21'd123100, 21'd125900, 21'd130600, 21'd137000, 21'd153200, 21'd171800, 21'd191200},
      '{21'd117570, 21'd118400, 21'd120900, 21'd125100, 21'd130700, 21'd145100, 21'd161800, 21'd179500},
      '{21'd109330, 21'd110000, 21'd111900, 21'd115000, 21'd119300, 21'd130400, 21'd143500, 21'd157800},
      '{21'd103880, 21'd104400, 21'd105900, 21'd108300, 21'd111700, 21'd120400, 21'd131000, 21'd142800},
      '{21'd99963, 21'd100400, 21'd101600, 21'd103500, 21'd106200, 21'd113300, 21'd122000, 21'd131900},
      '{21'd96988, 21'd97320, 21'd98300, 21'd99910, 21'd102100, 21'd107900, 21'd115300, 21'd123600},
      '{21'd92676, 21'd92910, 21'd93600, 21'd94730, 21'd96280, 21'd100500, 21'd105800, 21'd112100},
      '{21'd89616, 21'd89790, 21'd90300, 21'd91140, 21'd92300, 21'd95450, 21'd99550, 21'd104400},
      '{21'd87272, 21'd87410, 21'd87800, 21'd88450, 21'd89350, 21'd91810, 21'd95050, 21'd98930},
      '{21'd85379, 21'd85490, 21'd85800, 21'd86320, 21'd87030, 21'd89010, 21'd91640, 21'd94820},
      '{21'd83795, 21'd83880, 21'd84140, 21'd84560, 21'd85150, 21'd86780, 21'd88950, 21'd91600},
      '{21'd82435, 21'd82510, 21'd82730, 21'd83080, 21'd83560, 21'd84930, 21'd86760, 21'd89010},
      '{21'd80184, 21'd80240, 21'd80390, 21'd80650, 21'd81010, 21'd82010, 21'd83370, 21'd85040},
      '{21'd78363, 21'd78400, 21'd78520, 21'd78720, 21'd78990, 21'd79760, 21'd80810, 21'd82120},
      '{21'd76834, 21'd76870, 21'd76960, 21'd77120, 21'd77330, 21'd77940, 21'd78780, 21'd79830},
      '{21'd75518, 21'd75540, 21'd75620, 21'd75750, 21'd75920, 21'd76420, 21'd77110, 21'd77970},
      '{21'd74364, 21'd74380, 21'd74450, 21'd74550, 21'd74700, 21'd75120, 21'd75690, 21'd76420},
      '{21'd71982, 21'd72000, 21'd72040, 21'd72110, 21'd72210, 21'd72500, 21'd72890, 21'd73390},
      '{21'd70097, 21'd70110, 21'd70140, 21'd70190, 21'd70260, 21'd70470, 21'd70760, 21'd71120},
      '{21'd68545, 21'd68550, 21'd68580, 21'd68610, 21'd68670, 21'd68830, 21'd69050, 21'd69320},
      '{21'd67232, 21'd67240, 21'd67260, 21'd67280, 21'd67330, 21'd67430, 21'd67620, 21'd67840},
      '{21'd65099, 21'd65100, 21'd65120, 21'd65130, 21'd65160, 21'd65240, 21'd65340, 21'd65460},
      '{21'd61397, 21'd61410, 21'd61430, 21'd61450, 21'd61470, 21'd61480, 21'd61480, 21'd61470},
      '{21'd58870, 21'd58890, 21'd58940, 21'd59000, 21'd59030, 21'd59010, 21'd58950, 21'd58850}
   };

   localparam frac_type FRAC_ONE = 17'd65536;

   // half of 100000 * 65536, the final rounding offset
   localparam logic [53:0] ROUND_HALF = 54'd3276800000;
   // floor(2^43 / 3125)
   localparam logic [31:0] RECIP_3125 = 32'd2814749767;
   localparam logic [11:0] DIV_3125   = 12'd3125;

endpackage

// ----- src/cibl_out_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibl_out_div
// Three-stage rounding divide of the blended value by 100000 * 65536.
// ----------------------------------------------------------------------------
module cibl_out_div import cibl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [52:0] in_value,
   output logic        out_valid,
   output logic [19:0] out_value
);

   logic        a_vld_ff, b_vld_ff, c_vld_ff;
   logic [31:0] u_ff, u_in, u_b_ff;
   logic [63:0] prod_ff, prod_in;
   logic [19:0] q_ff, q_in;
   logic [53:0] sum;
   logic [20:0] q_est;
   logic [32:0] q_mul;
   logic [32:0] rem;

   // divide by 2^21 first, leaving a divide by 3125
   always_comb begin
      sum  = {1'b0, in_value} + ROUND_HALF;
      u_in = sum[52:21];
   end

   assign prod_in = 64'(u_ff) * 64'(RECIP_3125);

   // estimate is exact or one low
   always_comb begin
      q_est = prod_ff[63:43];
      q_mul = 33'(q_est) * 33'(DIV_3125);
      rem   = {1'b0, u_b_ff} - q_mul;
      if (rem >= 33'(DIV_3125)) begin
         q_in = q_est[19:0] + 20'd1;
      end else begin
         q_in = q_est[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      u_b_ff  <= u_ff;
      prod_ff <= prod_in;
      q_ff    <= q_in;
   end

   assign out_valid = c_vld_ff;
   assign out_value = q_ff;

endmodule

// ----- src/collision_integral_bilinear_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_integral_bilinear_lookup
// Omega(2,2) by bilinear interpolation over a 37x8 table on non-uniform axes.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_reduced_temperature, req_reduced_dipole   start & !busy
//  response  rsp_collision_integral                  rsp_valid, one cycle
//
//  one item per cycle; each result follows its start through the register stages and the divider
//  busy stays low: ten register stages with valid bits, no loop between them
//  multiplies sit in the offset, delta* blend and T* blend stages and in the divider
//  reset clears the valid bits only; the receiver cannot stall
// ----------------------------------------------------------------------------
module collision_integral_bilinear_lookup import cibl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_reduced_temperature,
   input  logic [19:0] req_reduced_dipole,
   output logic        rsp_valid,
   output logic [19:0] rsp_collision_integral
);

   logic [7:1] vld_ff;

   // stage 1: clamp and compare
   t_node_type            t_x_ff, t_x_in, t_x2_ff;
   d_node_type            d_x_ff, d_x_in, d_x2_ff;
   logic [TEMP_ROWS-2:0]   t_gt_ff, t_gt_in;
   logic [DIPOLE_COLS-2:0] d_gt_ff, d_gt_in;

   always_comb begin
      if (req_reduced_temperature < 24'(T_AXIS[0])) begin
         t_x_in = T_AXIS[0];
      end else if (req_reduced_temperature > 24'(T_AXIS[TEMP_ROWS-1])) begin
         t_x_in = T_AXIS[TEMP_ROWS-1];
      end else begin
         t_x_in = req_reduced_temperature[22:0];
      end
      if (req_reduced_dipole > 20'(D_AXIS[DIPOLE_COLS-1])) begin
         d_x_in = D_AXIS[DIPOLE_COLS-1];
      end else begin
         d_x_in = req_reduced_dipole[17:0];
      end
      for (int k = 0; k < TEMP_ROWS - 1; k++) begin
         t_gt_in[k] = t_x_in > T_AXIS[k+1];
      end
      for (int k = 0; k < DIPOLE_COLS - 1; k++) begin
         d_gt_in[k] = d_x_in > D_AXIS[k+1];
      end
   end

   // stage 2: interval index, whose upper node is the first node not below the input
   logic [T_IDX_W-1:0] t_idx_ff, t_idx_in, t_idx3_ff, t_idx4_ff;
   logic [D_IDX_W-1:0] d_idx_ff, d_idx_in, d_idx3_ff, d_idx4_ff;

   always_comb begin
      t_idx_in = T_IDX_W'(TEMP_ROWS - 2);
      for (int k = TEMP_ROWS - 2; k >= 0; k--) begin
         if (!t_gt_ff[k]) begin
            t_idx_in = T_IDX_W'(k);
         end
      end
      d_idx_in = D_IDX_W'(DIPOLE_COLS - 2);
      for (int k = DIPOLE_COLS - 2; k >= 0; k--) begin
         if (!d_gt_ff[k]) begin
            d_idx_in = D_IDX_W'(k);
         end
      end
   end

   // stage 3: offset from lower node and reciprocal lookup
   logic [20:0] t_off_ff, t_off_in;
   logic [15:0] d_off_ff, d_off_in;
   logic [19:0] t_rcp_ff;
   logic [18:0] d_rcp_ff;
   t_node_type  t_diff;
   d_node_type  d_diff;

   always_comb begin
      t_diff   = t_x2_ff - T_AXIS[t_idx_ff];
      d_diff   = d_x2_ff - D_AXIS[d_idx_ff];
      t_off_in = t_diff[20:0];
      d_off_in = d_diff[15:0];
   end

   // stage 4: offset times reciprocal
   logic [40:0] t_prod_ff, t_prod_in;
   logic [34:0] d_prod_ff, d_prod_in;

   assign t_prod_in = 41'(t_off_ff) * 41'(t_rcp_ff);
   assign d_prod_in = 35'(d_off_ff) * 35'(d_rcp_ff);

   // stage 5: fractions and corner fetch
   frac_type    t_f_ff, t_f_in, d_f_ff, d_f_in, t_f6_ff;
   omega_type   q00_ff, q01_ff, q10_ff, q11_ff;
   logic [41:0] t_rnd;
   logic [35:0] d_rnd;

   always_comb begin
      t_rnd = {1'b0, t_prod_ff} + 42'd32768;
      d_rnd = {1'b0, d_prod_ff} + 36'd32768;
      if (t_rnd[41:16] > 26'(FRAC_ONE)) begin
         t_f_in = FRAC_ONE;
      end else begin
         t_f_in = t_rnd[32:16];
      end
      if (d_rnd[35:16] > 20'(FRAC_ONE)) begin
         d_f_in = FRAC_ONE;
      end else begin
         d_f_in = d_rnd[32:16];
      end
   end

   // stage 6: blend along delta*
   logic [36:0] a_lo_ff, a_lo_in, a_hi_ff, a_hi_in;
   frac_type    d_g;

   always_comb begin
      d_g     = FRAC_ONE - d_f_ff;
      a_lo_in = 37'(q00_ff) * 37'(d_g) + 37'(q01_ff) * 37'(d_f_ff);
      a_hi_in = 37'(q10_ff) * 37'(d_g) + 37'(q11_ff) * 37'(d_f_ff);
   end

   // stage 7: partial products of the T* blend, split at bit 19
   logic [35:0] pp_ll_ff, pp_hl_ff;
   logic [34:0] pp_lh_ff, pp_hh_ff;
   frac_type    t_g;

   assign t_g = FRAC_ONE - t_f6_ff;

   // stage 8 onward in the divider
   logic [52:0] v_sum;
   logic [35:0] v_upper;

   always_comb begin
      v_upper = 36'(pp_lh_ff) + 36'(pp_hh_ff);
      v_sum   = {v_upper[33:0], 19'd0} + 53'(pp_ll_ff) + 53'(pp_hl_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:1], start};
      end
   end

   always_ff @(posedge clock) begin
      t_x_ff    <= t_x_in;
      d_x_ff    <= d_x_in;
      t_gt_ff   <= t_gt_in;
      d_gt_ff   <= d_gt_in;
      t_x2_ff   <= t_x_ff;
      d_x2_ff   <= d_x_ff;
      t_idx_ff  <= t_idx_in;
      d_idx_ff  <= d_idx_in;
      t_off_ff  <= t_off_in;
      d_off_ff  <= d_off_in;
      t_rcp_ff  <= T_RECIP[t_idx_ff];
      d_rcp_ff  <= D_RECIP[d_idx_ff];
      t_idx3_ff <= t_idx_ff;
      d_idx3_ff <= d_idx_ff;
      t_prod_ff <= t_prod_in;
      d_prod_ff <= d_prod_in;
      t_idx4_ff <= t_idx3_ff;
      d_idx4_ff <= d_idx3_ff;
      t_f_ff    <= t_f_in;
      d_f_ff    <= d_f_in;
      q00_ff    <= OMEGA_ROM[t_idx4_ff][d_idx4_ff];
      q01_ff    <= OMEGA_ROM[t_idx4_ff][d_idx4_ff + D_IDX_W'(1)];
      q10_ff    <= OMEGA_ROM[t_idx4_ff + T_IDX_W'(1)][d_idx4_ff];
      q11_ff    <= OMEGA_ROM[t_idx4_ff + T_IDX_W'(1)][d_idx4_ff + D_IDX_W'(1)];
      t_f6_ff   <= t_f_ff;
      a_lo_ff   <= a_lo_in;
      a_hi_ff   <= a_hi_in;
      pp_ll_ff  <= 36'(a_lo_ff[18:0]) * 36'(t_g);
      pp_lh_ff  <= 35'(a_lo_ff[36:19]) * 35'(t_g);
      pp_hl_ff  <= 36'(a_hi_ff[18:0]) * 36'(t_f6_ff);
      pp_hh_ff  <= 35'(a_hi_ff[36:19]) * 35'(t_f6_ff);
   end

   cibl_out_div u_out_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[7]),
      .in_value  (v_sum),
      .out_valid (rsp_valid),
      .out_value (rsp_collision_integral)
   );

   assign busy = 1'b0;

endmodule

// ----- src/cibl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cibl_checker
// Port-level checks of the lookup: fixed latency, no result without an item, result range and busy never raised.
// ----------------------------------------------------------------------------
module cibl_checker import cibl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [19:0] rsp_collision_integral
);

   logic acc;
   assign acc = start && !busy && !reset;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      acc |-> ##LATENCY rsp_valid)
      else $error("item without result");

   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc, LATENCY))
      else $error("result without item");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_collision_integral <= 20'd779223)
      else $error("result above table maximum");

   a_never_busy : assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind collision_integral_bilinear_lookup cibl_checker u_cibl_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_collision_integral (rsp_collision_integral)
);
